// File: rtl/bhc_pkg.sv
`timescale 1ns / 1ps
package bhc_pkg;

	localparam int MAX_STEPS       = 1024;
	localparam int MAX_STATE_BYTES = 512;
	localparam int PREFIX_BYTES    = 64;
	localparam int MSG_CAP         = PREFIX_BYTES + MAX_STATE_BYTES;
	localparam int LEN_W           = $clog2(MSG_CAP + 1);
	localparam int STEP_W          = $clog2(MAX_STEPS + 1);
	localparam int STEP_IDX_W      = 10;
	localparam int LAST_ROUND      = 11;

	localparam logic [63:0] PARAM_WORD = 64'h0000_0000_0101_0020;

	localparam logic [63:0] IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
		64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [63:0] SIGMA [10] = '{
		64'hfedcba9876543210, 64'h357b20c16df984ae,
		64'h491763eadf250c8b, 64'h8f04a562ebcd1397,
		64'hd386cb1efa427509, 64'h91ef57d438b0a6c2,
		64'hb8293670a4def15c, 64'ha2684f05931ce7bd,
		64'h5a417d2c803b9ef6, 64'h0dc3e9bf5167482a
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ABSORB,
		ST_POST,
		ST_END,
		ST_CINIT,
		ST_CRUN,
		ST_CDONE,
		ST_FIN,
		ST_OUT,
		ST_TAIL,
		ST_ERR
	} state_t;

	function automatic logic [3:0] sigma(input logic [3:0] rnd, input logic [3:0] pos);
		logic [3:0]  row;
		logic [63:0] word;
		row  = (rnd >= 4'd10) ? (rnd - 4'd10) : rnd;
		word = SIGMA[row];
		return word[{pos, 2'b00} +: 4];
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
	endfunction

	function automatic logic [63:0] swap64(input logic [63:0] x);
		logic [63:0] y;
		for (int i = 0; i < 8; i++) begin
			y[8*i +: 8] = x[8*(7-i) +: 8];
		end
		return y;
	endfunction

endpackage

// File: rtl/blake2b_hex_hash_chain_unit.sv
`timescale 1ns / 1ps
// BLAKE2b-256 hash chain over a trace of state strings.
// Input channel s_*: one item per state byte. s_tdata = state_byte,
// s_tuser = {last_of_trace, byte_present}, s_tlast = last_of_state.
// Output channel m_*: four items per emitted link, one 64-bit digest word
// each, m_tlast on word 3; an overflowed trace gives one item with error set.
// cfg_we / cfg_wdata write emit_all_links (1 emits every link, 0 only root).
// One shared 64-bit add/xor/rotate unit does a quarter mixing step per cycle.
// A byte item that crosses a 128-byte block adds a compression. The first
// item of every later state first absorbs 64 hex bytes, one per cycle
// unless a block compression comes between. A state end adds a final
// compression, and four output words when the link is emitted.
// s_tready is high only while the block is idle; one item is worked at once.
// When the receiver stalls, the block holds its result and waits.
// Reset clears the chain, loads the BLAKE2b-256 start vector and leaves
// the block idle and ready.
module blake2b_hex_hash_chain_unit
	import bhc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] state_byte
	input  logic [1:0]  s_tuser,   // [0] byte_present, [1] last_of_trace
	input  logic        s_tlast,   // last_of_state
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [63:0] digest_word, [65:64] word_index,
	                               // [66] is_root, [76:67] step_index,
	                               // [77] error, [79:78] zero
	output logic        m_tlast,   // last
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	state_t state_q, state_d;

	logic [63:0]       h_q [8];
	logic [63:0]       buf_q [16];
	logic [63:0]       prev_q [4];
	logic [63:0]       v_q [16];
	logic [LEN_W-1:0]  len_q;
	logic [STEP_W-1:0] step_q;
	logic              overflow_q;
	logic              emit_all_q;
	logic [7:0]        byte_q;
	logic              present_q, end_state_q, end_trace_q, hashing_q;
	logic              prefix_q, flushed_q, final_q;
	logic [5:0]        pcnt_q;
	logic [1:0]        ph_q;
	logic [2:0]        g_q;
	logic [3:0]        rnd_q;
	logic [1:0]        widx_q;
	logic [STEP_IDX_W-1:0] out_step_q;

	logic        s_acc, m_acc;
	logic        cap, flush;
	logic [63:0] pword;
	logic [7:0]  pbyte, cur_byte;
	logic [3:0]  pnib;
	logic [3:0]  ia, ib, ic, id, mi;
	logic [1:0]  k;
	logic        even;
	logic [63:0] op1, op2, op3, xin, sum, rx, rot;
	logic [3:0]  sum_dst, rot_dst;
	logic        last_step;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	assign cap   = (len_q >= LEN_W'(MSG_CAP));
	assign flush = !cap && (len_q[6:0] == 7'd0) && (len_q != '0) && !flushed_q;

	assign pword    = prev_q[pcnt_q[5:4]];
	assign pbyte    = pword[{3'd7 - pcnt_q[3:1], 3'b000} +: 8];
	assign pnib     = pcnt_q[0] ? pbyte[3:0] : pbyte[7:4];
	assign cur_byte = prefix_q ? hex_char(pnib) : byte_q;

	always_comb begin
		k = g_q[1:0];
		if (!g_q[2]) begin
			ia = {2'b00, k};
			ib = {2'b01, k};
			ic = {2'b10, k};
			id = {2'b11, k};
		end else begin
			ia = {2'b00, k};
			ib = {2'b01, k + 2'd1};
			ic = {2'b10, k + 2'd2};
			id = {2'b11, k + 2'd3};
		end
		mi   = sigma(rnd_q, {g_q, ph_q[1]});
		even = !ph_q[0];
		op1  = even ? v_q[ia] : v_q[ic];
		op2  = even ? v_q[ib] : v_q[id];
		op3  = even ? buf_q[mi] : 64'd0;
		xin  = even ? v_q[id] : v_q[ib];
		sum  = op1 + op2 + op3;
		rx   = xin ^ sum;
		case (ph_q)
			2'd0:    rot = {rx[31:0], rx[63:32]};
			2'd1:    rot = {rx[23:0], rx[63:24]};
			2'd2:    rot = {rx[15:0], rx[63:16]};
			default: rot = {rx[62:0], rx[63]};
		endcase
		sum_dst   = even ? ia : ic;
		rot_dst   = even ? id : ib;
		last_step = (ph_q == 2'd3) && (g_q == 3'd7) && (rnd_q == 4'(LAST_ROUND));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if ((step_q < STEP_W'(MAX_STEPS)) && (s_tuser[0] || s_tlast || s_tuser[1])) begin
						if ((step_q != '0 && len_q == '0) || s_tuser[0]) begin
							state_d = ST_ABSORB;
						end else begin
							state_d = ST_POST;
						end
					end else begin
						state_d = ST_POST;
					end
				end
			end
			ST_ABSORB: begin
				if (flush) begin
					state_d = ST_CINIT;
				end else if (!prefix_q || (pcnt_q == 6'd63 && !present_q)) begin
					state_d = ST_POST;
				end
			end
			ST_POST:  state_d = end_state_q ? ST_END : ST_IDLE;
			ST_END:   state_d = hashing_q ? ST_CINIT : ST_TAIL;
			ST_CINIT: state_d = ST_CRUN;
			ST_CRUN: begin
				if (last_step) begin
					state_d = ST_CDONE;
				end
			end
			ST_CDONE: state_d = final_q ? ST_FIN : ST_ABSORB;
			ST_FIN:   state_d = (emit_all_q || end_trace_q) ? ST_OUT : ST_TAIL;
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready && widx_q == 2'd3) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				if (end_trace_q && overflow_q) begin
					state_d = ST_ERR;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		if (state_q == ST_ERR) begin
			m_tdata = {2'b00, 1'b1, {STEP_IDX_W{1'b0}}, 1'b1, 2'd0, 64'd0};
			m_tlast = 1'b1;
		end else begin
			m_tdata = {2'b00, 1'b0, out_step_q, end_trace_q, widx_q, prev_q[widx_q]};
			m_tlast = (widx_q == 2'd3);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CINIT) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i]   <= h_q[i];
				v_q[i+8] <= IV[i];
			end
			v_q[12] <= IV[4] ^ {{(64-LEN_W){1'b0}}, len_q};
			v_q[14] <= final_q ? ~IV[6] : IV[6];
		end else if (state_q == ST_CRUN) begin
			v_q[sum_dst] <= sum;
			v_q[rot_dst] <= rot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= IV[i];
			end
			h_q[0] <= IV[0] ^ PARAM_WORD;
			for (int i = 0; i < 16; i++) begin
				buf_q[i] <= 64'd0;
			end
			for (int i = 0; i < 4; i++) begin
				prev_q[i] <= 64'd0;
			end
			len_q       <= '0;
			step_q      <= '0;
			overflow_q  <= 1'b0;
			emit_all_q  <= 1'b0;
			byte_q      <= 8'd0;
			present_q   <= 1'b0;
			end_state_q <= 1'b0;
			end_trace_q <= 1'b0;
			hashing_q   <= 1'b0;
			prefix_q    <= 1'b0;
			flushed_q   <= 1'b0;
			final_q     <= 1'b0;
			pcnt_q      <= 6'd0;
			ph_q        <= 2'd0;
			g_q         <= 3'd0;
			rnd_q       <= 4'd0;
			widx_q      <= 2'd0;
			out_step_q  <= '0;
		end else begin
			if (cfg_we) begin
				emit_all_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						byte_q      <= s_tdata;
						present_q   <= s_tuser[0];
						end_trace_q <= s_tuser[1];
						end_state_q <= s_tlast || s_tuser[1];
						hashing_q   <= step_q < STEP_W'(MAX_STEPS);
						prefix_q    <= (step_q != '0) && (len_q == '0);
						pcnt_q      <= 6'd0;
						flushed_q   <= 1'b0;
					end
				end
				ST_ABSORB: begin
					if (flush) begin
						final_q <= 1'b0;
					end else begin
						if (!cap) begin
							buf_q[len_q[6:3]][{len_q[2:0], 3'b000} +: 8] <= cur_byte;
							len_q     <= len_q + LEN_W'(1);
							flushed_q <= 1'b0;
						end
						if (prefix_q) begin
							pcnt_q <= pcnt_q + 6'd1;
							if (pcnt_q == 6'd63) begin
								prefix_q <= 1'b0;
							end
						end
					end
				end
				ST_END: begin
					if (hashing_q) begin
						final_q <= 1'b1;
					end else begin
						overflow_q <= 1'b1;
					end
				end
				ST_CINIT: begin
					ph_q  <= 2'd0;
					g_q   <= 3'd0;
					rnd_q <= 4'd0;
				end
				ST_CRUN: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						g_q <= g_q + 3'd1;
						if (g_q == 3'd7) begin
							rnd_q <= rnd_q + 4'd1;
						end
					end
				end
				ST_CDONE: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
					end
					if (!final_q) begin
						for (int i = 0; i < 16; i++) begin
							buf_q[i] <= 64'd0;
						end
						flushed_q <= 1'b1;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 4; i++) begin
						prev_q[i] <= swap64(h_q[i]);
					end
					out_step_q <= step_q[STEP_IDX_W-1:0];
					step_q     <= step_q + STEP_W'(1);
					widx_q     <= 2'd0;
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= IV[i];
					end
					h_q[0] <= IV[0] ^ PARAM_WORD;
					for (int i = 0; i < 16; i++) begin
						buf_q[i] <= 64'd0;
					end
					len_q <= '0;
				end
				ST_OUT: begin
					if (m_acc) begin
						widx_q <= widx_q + 2'd1;
					end
				end
				ST_TAIL: begin
					if (!hashing_q) begin
						for (int i = 0; i < 8; i++) begin
							h_q[i] <= IV[i];
						end
						h_q[0] <= IV[0] ^ PARAM_WORD;
						for (int i = 0; i < 16; i++) begin
							buf_q[i] <= 64'd0;
						end
						len_q <= '0;
					end
					if (end_trace_q && !overflow_q) begin
						step_q <= '0;
						for (int i = 0; i < 4; i++) begin
							prev_q[i] <= 64'd0;
						end
					end
				end
				ST_ERR: begin
					if (m_acc) begin
						step_q     <= '0;
						overflow_q <= 1'b0;
						for (int i = 0; i < 4; i++) begin
							prev_q[i] <= 64'd0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: dv/blake2b_hex_hash_chain_unit_tb.sv
`timescale 1ns / 1ps
module blake2b_hex_hash_chain_unit_tb;
	import bhc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 1200;
	localparam int CHAIN_CAP      = 576;

	typedef struct packed {
		bit [7:0] data;
		bit       present;
		bit       end_state;
		bit       end_trace;
	} trace_item_t;

	typedef struct packed {
		bit [63:0] word;
		bit [1:0]  idx;
		bit        root;
		bit [9:0]  step;
		bit        err;
		bit        last;
	} digest_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we;
	logic        cfg_wdata;

	blake2b_hex_hash_chain_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	trace_item_t  trace_q[$];
	digest_word_t digest_q[$];

	bit [63:0]   hs[8];
	bit [63:0]   blk[16];
	bit [63:0]   prev_link[4];
	bit [63:0]   vv[16];
	int unsigned msg_len;
	int unsigned links_done;
	bit          overflowed;
	bit          emit_every_link;

	bit s_fire;
	bit s_calm;
	int s_gap;
	int m_stall;
	bit m_calm;
	int idle_cycles;
	int mismatches;
	int items_sent;
	int words_checked;
	int traces_sent;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic bit [63:0] ror64(bit [63:0] x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function void quarter_mix(int a, int b, int c, int d, bit [63:0] x, bit [63:0] y);
		vv[a] = vv[a] + vv[b] + x;
		vv[d] = ror64(vv[d] ^ vv[a], 32);
		vv[c] = vv[c] + vv[d];
		vv[b] = ror64(vv[b] ^ vv[c], 24);
		vv[a] = vv[a] + vv[b] + y;
		vv[d] = ror64(vv[d] ^ vv[a], 16);
		vv[c] = vv[c] + vv[d];
		vv[b] = ror64(vv[b] ^ vv[c], 63);
	endfunction

	function void block_compress(bit [63:0] cnt, bit fin);
		bit [63:0] row;
		for (int i = 0; i < 8; i++) begin
			vv[i]     = hs[i];
			vv[i + 8] = IV[i];
		end
		vv[12] ^= cnt;
		if (fin) begin
			vv[14] = ~vv[14];
		end
		for (int r = 0; r < 12; r++) begin
			row = SIGMA[r % 10];
			quarter_mix(0, 4, 8, 12, blk[row[3:0]], blk[row[7:4]]);
			quarter_mix(1, 5, 9, 13, blk[row[11:8]], blk[row[15:12]]);
			quarter_mix(2, 6, 10, 14, blk[row[19:16]], blk[row[23:20]]);
			quarter_mix(3, 7, 11, 15, blk[row[27:24]], blk[row[31:28]]);
			quarter_mix(0, 5, 10, 15, blk[row[35:32]], blk[row[39:36]]);
			quarter_mix(1, 6, 11, 12, blk[row[43:40]], blk[row[47:44]]);
			quarter_mix(2, 7, 8, 13, blk[row[51:48]], blk[row[55:52]]);
			quarter_mix(3, 4, 9, 14, blk[row[59:56]], blk[row[63:60]]);
		end
		for (int i = 0; i < 8; i++) begin
			hs[i] ^= vv[i] ^ vv[i + 8];
		end
	endfunction

	function void open_message();
		for (int i = 0; i < 8; i++) begin
			hs[i] = IV[i];
		end
		hs[0] ^= PARAM_WORD;
		for (int i = 0; i < 16; i++) begin
			blk[i] = '0;
		end
		msg_len = 0;
	endfunction

	function void take_byte(bit [7:0] b);
		int unsigned pos;
		if (msg_len >= CHAIN_CAP) begin
			return;
		end
		pos = msg_len % 128;
		if (pos == 0 && msg_len != 0) begin
			block_compress(64'(msg_len), 1'b0);
			for (int i = 0; i < 16; i++) begin
				blk[i] = '0;
			end
		end
		blk[pos / 8][(pos % 8) * 8 +: 8] = b;
		msg_len++;
	endfunction

	function automatic bit [7:0] nibble_ascii(bit [3:0] nib);
		return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
	endfunction

	function void take_prev_hex();
		bit [7:0] b;
		for (int j = 0; j < 32; j++) begin
			b = prev_link[j / 8][63 - 8 * (j % 8) -: 8];
			take_byte(nibble_ascii(b[7:4]));
			take_byte(nibble_ascii(b[3:0]));
		end
	endfunction

	function void clear_chain();
		open_message();
		for (int i = 0; i < 4; i++) begin
			prev_link[i] = '0;
		end
		links_done = 0;
		overflowed = 1'b0;
	endfunction

	function void chain_take_item(trace_item_t it);
		bit           hashing;
		bit           ends;
		bit [63:0]    link[4];
		digest_word_t d;
		ends    = it.end_state || it.end_trace;
		hashing = links_done < MAX_STEPS;
		if (hashing && (it.present || ends)) begin
			if (links_done != 0 && msg_len == 0) begin
				take_prev_hex();
			end
			if (it.present) begin
				take_byte(it.data);
			end
		end
		if (!ends) begin
			return;
		end
		if (hashing) begin
			block_compress(64'(msg_len), 1'b1);
			for (int k = 0; k < 4; k++) begin
				for (int i = 0; i < 8; i++) begin
					link[k][8 * i +: 8] = hs[k][8 * (7 - i) +: 8];
				end
				prev_link[k] = link[k];
			end
			if (!overflowed && (emit_every_link || it.end_trace)) begin
				for (int k = 0; k < 4; k++) begin
					d.word = link[k];
					d.idx  = 2'(k);
					d.root = it.end_trace;
					d.step = links_done[9:0];
					d.err  = 1'b0;
					d.last = (k == 3);
					digest_q.push_back(d);
				end
			end
			links_done++;
		end else begin
			overflowed = 1'b1;
		end
		open_message();
		if (it.end_trace) begin
			if (overflowed) begin
				d = '0;
				d.root = 1'b1;
				d.err  = 1'b1;
				d.last = 1'b1;
				digest_q.push_back(d);
			end
			clear_chain();
		end
	endfunction

	// drive inputs on the falling edge
	always @(negedge clk) begin
		trace_item_t it;
		if (arst_n && (!s_tvalid || s_fire)) begin
			if (s_gap > 0) begin
				s_gap--;
				s_tvalid <= 1'b0;
			end else if (trace_q.size() != 0) begin
				it = trace_q.pop_front();
				s_tdata  <= it.data;
				s_tuser  <= {it.end_trace, it.present};
				s_tlast  <= it.end_state;
				s_tvalid <= 1'b1;
				s_gap = s_calm ? 0 : $urandom_range(0, 7);
				if ($urandom_range(0, 15) == 0) begin
					s_calm = !s_calm;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		if (m_stall > 0) begin
			m_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// sample both channels on the rising edge
	always @(posedge clk) begin
		trace_item_t  it;
		digest_word_t got;
		digest_word_t want;
		s_fire <= s_tvalid && s_tready;
		if (arst_n) begin
			idle_cycles++;
			if (s_tvalid && s_tready) begin
				idle_cycles = 0;
				it.data      = s_tdata;
				it.present   = s_tuser[0];
				it.end_trace = s_tuser[1];
				it.end_state = s_tlast;
				chain_take_item(it);
			end
			if (m_tvalid && m_tready) begin
				idle_cycles = 0;
				got.word = m_tdata[63:0];
				got.idx  = m_tdata[65:64];
				got.root = m_tdata[66];
				got.step = m_tdata[76:67];
				got.err  = m_tdata[77];
				got.last = m_tlast;
				m_stall = m_calm ? 0 : $urandom_range(0, 7);
				if ($urandom_range(0, 15) == 0) begin
					m_calm = !m_calm;
				end
				if (digest_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected item: word %h idx %0d root %0d step %0d err %0d last %0d",
							got.word, got.idx, got.root, got.step, got.err, got.last);
					end
				end else begin
					want = digest_q.pop_front();
					words_checked++;
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected word %h idx %0d root %0d step %0d err %0d last %0d",
								want.word, want.idx, want.root, want.step, want.err, want.last);
							$display("          actual   word %h idx %0d root %0d step %0d err %0d last %0d",
								got.word, got.idx, got.root, got.step, got.err, got.last);
						end
					end
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	function void push_item(bit [7:0] b, bit p, bit es, bit et);
		trace_item_t it;
		it.data      = b;
		it.present   = p;
		it.end_state = es;
		it.end_trace = et;
		trace_q.push_back(it);
		if (p || es || et) begin
			items_sent++;
		end
	endfunction

	// one state string; an empty one is a bare end mark
	function void push_state(int len, bit closes_trace, bit drop_state_mark);
		if (len == 0) begin
			push_item(8'($urandom), 1'b0, !closes_trace || !drop_state_mark, closes_trace);
			return;
		end
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				push_item(8'($urandom), 1'b0, 1'b0, 1'b0);
			end
			if (i == len - 1) begin
				push_item(8'($urandom), 1'b1, !(closes_trace && drop_state_mark), closes_trace);
			end else begin
				push_item(8'($urandom), 1'b1, 1'b0, 1'b0);
			end
		end
	endfunction

	task automatic settle();
		while (trace_q.size() != 0 || s_tvalid || digest_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_emit_mode(bit v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		emit_every_link = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int n;
		int len;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		s_fire    = 1'b0;
		s_calm    = 1'b0;
		m_calm    = 1'b0;
		s_gap     = 0;
		m_stall   = 0;
		emit_every_link = 1'b0;
		clear_chain();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: edge bytes, empty states, noise, trace end without state end
		write_emit_mode(1'b1);
		push_item(8'h00, 1'b0, 1'b1, 1'b1);
		push_item(8'h00, 1'b1, 1'b0, 1'b0);
		push_item(8'hff, 1'b1, 1'b0, 1'b0);
		push_item(8'h61, 1'b1, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b1, 1'b0);
		push_item(8'h5a, 1'b1, 1'b0, 1'b0);
		push_item(8'h33, 1'b0, 1'b0, 1'b0);
		push_item(8'ha5, 1'b1, 1'b1, 1'b0);
		push_item(8'h80, 1'b1, 1'b0, 1'b0);
		push_item(8'h7f, 1'b1, 1'b0, 1'b1);
		push_item(8'hff, 1'b1, 1'b1, 1'b1);
		push_item(8'h12, 1'b0, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b0, 1'b1);
		traces_sent += 4;
		settle();

		// long states: cut at the message cap, block boundaries
		write_emit_mode(1'b0);
		push_state(600, 1'b0, 1'b0);
		push_state(530, 1'b0, 1'b0);
		push_state(64, 1'b0, 1'b0);
		push_state(128, 1'b1, 1'b0);
		push_state(128, 1'b1, 1'b0);
		traces_sent += 2;
		settle();

		// random traces, switching the emit mode between batches
		for (int phase = 0; phase < 4; phase++) begin
			write_emit_mode(phase[0]);
			n = items_sent;
			while (items_sent - n < 80) begin
				len = $urandom_range(1, 5);
				for (int s = 0; s < len; s++) begin
					if ($urandom_range(0, 24) == 0) begin
						push_state($urandom_range(120, 140), s == len - 1, 1'b0);
					end else begin
						push_state($urandom_range(0, 12), s == len - 1,
							$urandom_range(0, 3) == 0);
					end
				end
				traces_sent++;
			end
			settle();
		end

		// step bound: two states past the limit, then a fresh trace
		write_emit_mode(1'b0);
		for (int s = 0; s < MAX_STEPS + 2; s++) begin
			push_state(0, s == MAX_STEPS + 1, 1'b0);
		end
		push_state(3, 1'b0, 1'b0);
		push_state(2, 1'b1, 1'b0);
		traces_sent += 2;
		settle();

		$display("sent %0d items in %0d traces, incl. long states and step-bound overflow",
			items_sent, traces_sent);
		$display("checked %0d digest items, %0d mismatches", words_checked, mismatches);
		if (mismatches == 0 && digest_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
